// ----- design/ordered_list_position_edit_top_assert.svh -----
// Assertion macros shared by the ordered list checker.
`ifndef ORDERED_LIST_POSITION_EDIT_TOP_ASSERT_SVH
`define ORDERED_LIST_POSITION_EDIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered list check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OLPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered list check failed");

`endif

// ----- design/olpe_pkg.sv -----
// Shared constants and types for the ordered list block.
`default_nettype none

package olpe_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CMP_W  = 10;

  // Command codes
  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_END   = 3'd1;
  localparam logic [2:0] CMD_INS_POS   = 3'd2;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [2:0] CMD_DEL_END   = 3'd4;
  localparam logic [2:0] CMD_DEL_POS   = 3'd5;
  localparam logic [2:0] CMD_SHOW      = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Cell source select
  typedef logic [1:0] sel_t;
  localparam sel_t SEL_HOLD  = 2'd0;
  localparam sel_t SEL_LEFT  = 2'd1;
  localparam sel_t SEL_RIGHT = 2'd2;
  localparam sel_t SEL_LOAD  = 2'd3;

endpackage

`default_nettype wire

// ----- design/olpe_cell.sv -----
// One storage cell of the list chain.
`default_nettype none

module olpe_cell (
  input  wire logic                        clk,
  input  wire olpe_pkg::sel_t              sel,
  input  wire logic [olpe_pkg::DATA_W-1:0] left_in,
  input  wire logic [olpe_pkg::DATA_W-1:0] right_in,
  input  wire logic [olpe_pkg::DATA_W-1:0] load_val,
  output logic      [olpe_pkg::DATA_W-1:0] data
);

  logic [olpe_pkg::DATA_W-1:0] data_r;
  logic [olpe_pkg::DATA_W-1:0] data_nxt;

  // Pick the source for this cycle
  always_comb begin
    case (sel)
      olpe_pkg::SEL_LEFT:  data_nxt = left_in;
      olpe_pkg::SEL_RIGHT: data_nxt = right_in;
      olpe_pkg::SEL_LOAD:  data_nxt = load_val;
      default:             data_nxt = data_r;
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ----- design/ordered_list_position_edit_top.sv -----
// For an edit the result is registered and appears the cycle after the transfer.
// An edit can be taken every cycle while the result slot drains; no stall between edits.
// Display first enters S_SHOW, then registers one result per entry from cell 0,
// one per cycle while the result slot drains; input stays blocked until the last one.
// The cell chain rotates once per display result, so the list is restored at the end.
// Reset (synchronous, active low) empties the list; cell contents are not cleared.
`default_nettype none

module ordered_list_position_edit_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [31:0] in_value,
  input  wire logic [7:0]         in_position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_value_res,
  output logic [4:0]              out_index,
  output logic [4:0]              out_count,
  output logic                    out_last
);

  localparam logic S_CMD  = 1'b0;
  localparam logic S_SHOW = 1'b1;

  logic                          state_r;
  logic [olpe_pkg::CNT_W-1:0]    count_r;
  logic [olpe_pkg::CNT_W-1:0]    k_r;
  logic                          out_valid_r;
  logic [1:0]                    status_r;
  logic [olpe_pkg::DATA_W-1:0]   value_r;
  logic [4:0]                    index_r;
  logic                          last_r;

  logic [olpe_pkg::DATA_W-1:0]   cell_data [olpe_pkg::DEPTH];
  logic [olpe_pkg::DATA_W-1:0]   cell_left [olpe_pkg::DEPTH];
  logic [olpe_pkg::DATA_W-1:0]   cell_right[olpe_pkg::DEPTH];
  olpe_pkg::sel_t                cell_sel  [olpe_pkg::DEPTH];

  logic                          slot_free;
  logic                          in_fire;
  logic                          show_fire;
  logic                          full;
  logic                          empty;
  logic                          do_ins;
  logic                          do_del;
  logic [1:0]                    st;
  logic [olpe_pkg::CMP_W-1:0]    cnt_ext;
  logic [olpe_pkg::CMP_W-1:0]    pos_ext;
  logic [olpe_pkg::CMP_W-1:0]    slot_w;
  logic [olpe_pkg::PTR_W-1:0]    slot;
  logic [olpe_pkg::PTR_W-1:0]    tail_idx;
  logic [olpe_pkg::CNT_W-1:0]    k_nxt;
  logic                          show_last;

  // Handshake
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_CMD) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign show_fire = (state_r == S_SHOW) && slot_free;

  assign full      = (count_r == olpe_pkg::CNT_W'(olpe_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign cnt_ext   = olpe_pkg::CMP_W'(count_r);
  assign pos_ext   = olpe_pkg::CMP_W'(in_position);
  assign tail_idx  = olpe_pkg::PTR_W'(count_r - 1'b1);
  assign k_nxt     = k_r + 1'b1;
  assign show_last = (k_nxt == count_r);

  // Decode the command: status and the slot to edit
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    st     = olpe_pkg::ST_OK;
    slot_w = '0;
    case (in_command)
      olpe_pkg::CMD_INS_FRONT, olpe_pkg::CMD_INS_END, olpe_pkg::CMD_INS_POS: begin
        if (full) begin
          st = olpe_pkg::ST_FULL;
        end else if (in_command == olpe_pkg::CMD_INS_FRONT) begin
          do_ins = 1'b1;
        end else if (in_command == olpe_pkg::CMD_INS_END) begin
          do_ins = 1'b1;
          slot_w = cnt_ext;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
          st = olpe_pkg::ST_RANGE;
        end else begin
          do_ins = 1'b1;
          slot_w = pos_ext - 1'b1;
        end
      end
      olpe_pkg::CMD_DEL_FRONT, olpe_pkg::CMD_DEL_END, olpe_pkg::CMD_DEL_POS: begin
        if (empty) begin
          st = olpe_pkg::ST_EMPTY;
        end else if (in_command == olpe_pkg::CMD_DEL_FRONT) begin
          do_del = 1'b1;
        end else if (in_command == olpe_pkg::CMD_DEL_END) begin
          do_del = 1'b1;
          slot_w = cnt_ext - 1'b1;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          st = olpe_pkg::ST_RANGE;
        end else begin
          do_del = 1'b1;
          slot_w = pos_ext - 1'b1;
        end
      end
      olpe_pkg::CMD_SHOW: begin
        if (empty) begin
          st = olpe_pkg::ST_EMPTY;
        end
      end
      default: begin
        st = olpe_pkg::ST_OK;
      end
    endcase
  end

  assign slot = olpe_pkg::PTR_W'(slot_w);

  // Per-cell source select: shift right on insert, left on delete, rotate on display
  always_comb begin
    for (int i = 0; i < olpe_pkg::DEPTH; i++) begin
      cell_sel[i] = olpe_pkg::SEL_HOLD;
      if (in_fire && do_ins) begin
        if (olpe_pkg::PTR_W'(i) > slot) begin
          cell_sel[i] = olpe_pkg::SEL_LEFT;
        end else if (olpe_pkg::PTR_W'(i) == slot) begin
          cell_sel[i] = olpe_pkg::SEL_LOAD;
        end
      end else if (in_fire && do_del) begin
        if (olpe_pkg::PTR_W'(i) >= slot) begin
          cell_sel[i] = olpe_pkg::SEL_RIGHT;
        end
      end else if (show_fire) begin
        cell_sel[i] = olpe_pkg::SEL_RIGHT;
      end
    end
  end

  // Chain of cells; the head wraps round to the tail during display
  for (genvar g = 0; g < olpe_pkg::DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_left[g] = in_value;
    end else begin : g_body
      assign cell_left[g] = cell_data[g-1];
    end
    if (g == olpe_pkg::DEPTH - 1) begin : g_end
      assign cell_right[g] = cell_data[0];
    end else begin : g_mid
      assign cell_right[g] = (olpe_pkg::PTR_W'(g) == tail_idx) ? cell_data[0] : cell_data[g+1];
    end

    olpe_cell u_cell (
      .clk      (clk),
      .sel      (cell_sel[g]),
      .left_in  (cell_left[g]),
      .right_in (cell_right[g]),
      .load_val (in_value),
      .data     (cell_data[g])
    );
  end

  // Control state: list length, display walk, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CMD;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_command == olpe_pkg::CMD_SHOW && !empty) begin
          state_r     <= S_SHOW;
          k_r         <= '0;
          out_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b1;
          if (do_ins) begin
            count_r <= count_r + 1'b1;
          end else if (do_del) begin
            count_r <= count_r - 1'b1;
          end
        end
      end else if (show_fire) begin
        out_valid_r <= 1'b1;
        k_r         <= k_nxt;
        if (show_last) begin
          state_r <= S_CMD;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= st;
      value_r  <= do_del ? cell_data[slot] : '0;
      index_r  <= '0;
      last_r   <= 1'b1;
    end else if (show_fire) begin
      status_r <= olpe_pkg::ST_OK;
      value_r  <= cell_data[0];
      index_r  <= 5'(k_nxt);
      last_r   <= show_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_value_res = value_r;
  assign out_index     = index_r;
  assign out_count     = 5'(count_r);
  assign out_last      = last_r;

endmodule

`default_nettype wire

// ----- design/olpe_checker.sv -----
// Port-level checks for the ordered list block, bound to the top level.
`default_nettype none

`include "ordered_list_position_edit_top_assert.svh"

module olpe_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_status,
  input wire logic signed [31:0] out_value_res,
  input wire logic [4:0]         out_index,
  input wire logic [4:0]         out_count,
  input wire logic               out_last
);

  // A stalled result stays
  `OLPE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A stalled result keeps its value
  `OLPE_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_value_res))

  // The single result slot blocks input while it is stalled
  `OLPE_ASSERT_IMP(a_no_take_when_blocked, out_valid && !out_ready, !in_ready)

  // A non-final result only comes from a display walk
  `OLPE_ASSERT_IMP(a_mid_show, out_valid && !out_last, out_status == olpe_pkg::ST_OK && out_index != 5'd0)

  // The list never holds more entries than its capacity
  `OLPE_ASSERT_IMP(a_count_max, out_valid, out_count <= 5'(olpe_pkg::DEPTH))

endmodule

bind ordered_list_position_edit_top olpe_checker u_olpe_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
// Testbench for the ordered list block: directed table, then random commands against a model.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code the block ignores; it still answers with one result
  localparam logic [2:0] CMD_UNUSED  = 3'd7;
  localparam int         RAND_ITEMS  = 300;
  localparam int         HOLD_CYCLES = 60;
  localparam int         IDLE_LIMIT  = 2000;
  localparam int         MAX_REPORTS = 10;
  localparam int         SETTLE      = 20;

  localparam logic [2:0] INS_CMDS [3] = '{olpe_pkg::CMD_INS_FRONT, olpe_pkg::CMD_INS_END,
                                           olpe_pkg::CMD_INS_POS};
  localparam logic [2:0] DEL_CMDS [3] = '{olpe_pkg::CMD_DEL_FRONT, olpe_pkg::CMD_DEL_END,
                                           olpe_pkg::CMD_DEL_POS};

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [4:0]         index;
    logic [4:0]         count;
    logic               last;
  } list_result_t;

  typedef struct {
    logic [2:0]   cmd;
    logic [31:0]  value;
    logic [7:0]   pos;
    int           reps;
    bit           typed;
    list_result_t res;
  } edit_row_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [2:0]         in_command    = olpe_pkg::CMD_INS_FRONT;
  logic signed [31:0] in_value      = '0;
  logic [7:0]         in_position   = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_value_res;
  logic [4:0]         out_index;
  logic [4:0]         out_count;
  logic               out_last;

  // Shadow copy of the list, updated at each input transfer
  logic [31:0]  shadow_list [olpe_pkg::DEPTH];
  int           shadow_len;
  list_result_t pending_results [$];
  edit_row_t    directed_rows [$];

  bit send_burst;
  bit recv_burst;
  bit hold_req;
  bit hold_window;

  int mismatches;
  int results_checked;
  int items_sent;
  int shows_sent;
  int hits_full;
  int hits_empty;
  int hits_range;
  int longest_list;
  int idle_cycles;

  ordered_list_position_edit_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_value     (in_value),
    .in_position  (in_position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_value_res(out_value_res),
    .out_index    (out_index),
    .out_count    (out_count),
    .out_last     (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the shadow list and return the results it should produce
  function automatic void apply_list_edit(input logic [2:0] cmd, input logic [31:0] val,
                                          input logic [7:0] pos, output list_result_t res [$]);
    list_result_t r;
    int           slot;
    int           i;
    r    = '{status: olpe_pkg::ST_OK, value: '0, index: '0, count: '0, last: 1'b1};
    res  = {};
    slot = -1;
    case (cmd)
      olpe_pkg::CMD_INS_FRONT, olpe_pkg::CMD_INS_END, olpe_pkg::CMD_INS_POS: begin
        // Full takes priority over a bad position
        if (shadow_len >= olpe_pkg::DEPTH) r.status = olpe_pkg::ST_FULL;
        else if (cmd == olpe_pkg::CMD_INS_FRONT) slot = 0;
        else if (cmd == olpe_pkg::CMD_INS_END) slot = shadow_len;
        else if (pos < 1 || pos > shadow_len + 1) r.status = olpe_pkg::ST_RANGE;
        else slot = pos - 1;
        if (slot >= 0) begin
          for (i = shadow_len; i > slot; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[slot] = val;
          shadow_len++;
        end
      end
      olpe_pkg::CMD_DEL_FRONT, olpe_pkg::CMD_DEL_END, olpe_pkg::CMD_DEL_POS: begin
        // Empty takes priority over a bad position
        if (shadow_len == 0) r.status = olpe_pkg::ST_EMPTY;
        else if (cmd == olpe_pkg::CMD_DEL_FRONT) slot = 0;
        else if (cmd == olpe_pkg::CMD_DEL_END) slot = shadow_len - 1;
        else if (pos < 1 || pos > shadow_len) r.status = olpe_pkg::ST_RANGE;
        else slot = pos - 1;
        if (slot >= 0) begin
          r.value = shadow_list[slot];
          for (i = slot; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
        end
      end
      olpe_pkg::CMD_SHOW: begin
        if (shadow_len == 0) r.status = olpe_pkg::ST_EMPTY;
        else begin
          for (i = 0; i < shadow_len; i++) begin
            r.value = shadow_list[i];
            r.index = 5'(i + 1);
            r.count = 5'(shadow_len);
            r.last  = (i == shadow_len - 1);
            res.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.count = 5'(shadow_len);
    res.push_back(r);
  endfunction

  function automatic void add_row(input logic [2:0] cmd, input logic [31:0] val,
                                  input logic [7:0] pos, input int reps, input bit typed,
                                  input logic [1:0] st, input int cnt);
    edit_row_t row;
    row.cmd   = cmd;
    row.value = val;
    row.pos   = pos;
    row.reps  = reps;
    row.typed = typed;
    row.res   = '{status: st, value: '0, index: '0, count: 5'(cnt), last: 1'b1};
    directed_rows.push_back(row);
  endfunction

  // Favour the extremes of the value range
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one command, hold it until the transfer, then record what it should return
  task automatic send_edit(input logic [2:0] cmd, input logic [31:0] val, input logic [7:0] pos,
                           input bit typed, input list_result_t typed_res);
    int           gap;
    list_result_t res [$];
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    gap = (send_burst || hold_window) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    apply_list_edit(cmd, val, pos, res);
    if (typed) res = '{typed_res};
    foreach (res[k]) pending_results.push_back(res[k]);
    case (res[0].status)
      olpe_pkg::ST_FULL:  hits_full++;
      olpe_pkg::ST_EMPTY: hits_empty++;
      olpe_pkg::ST_RANGE: hits_range++;
      default: ;
    endcase
    if (cmd == olpe_pkg::CMD_SHOW) shows_sent++;
    if (shadow_len > longest_list) longest_list = shadow_len;
    items_sent++;
  endtask

  // Stimulus: reset, directed table, random commands, drain
  initial begin : stimulus
    int           roll;
    bit           filling;
    logic [2:0]   cmd;
    logic [7:0]   pos;
    edit_row_t    row;
    shadow_len = 0;
    filling    = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Edits against an empty list, then bad positions around a short list
    add_row(olpe_pkg::CMD_DEL_FRONT, '0, 8'd0, 1, 1'b1, olpe_pkg::ST_EMPTY, 0);
    add_row(olpe_pkg::CMD_DEL_END, '0, 8'd0, 1, 1'b1, olpe_pkg::ST_EMPTY, 0);
    add_row(olpe_pkg::CMD_DEL_POS, '0, 8'd1, 1, 1'b1, olpe_pkg::ST_EMPTY, 0);
    add_row(olpe_pkg::CMD_SHOW, '0, 8'd0, 1, 1'b1, olpe_pkg::ST_EMPTY, 0);
    add_row(CMD_UNUSED, 32'hFFFF_FFFF, 8'd255, 1, 1'b1, olpe_pkg::ST_OK, 0);
    add_row(olpe_pkg::CMD_INS_POS, 32'd5, 8'd0, 1, 1'b1, olpe_pkg::ST_RANGE, 0);
    add_row(olpe_pkg::CMD_INS_POS, 32'd5, 8'd2, 1, 1'b1, olpe_pkg::ST_RANGE, 0);
    add_row(olpe_pkg::CMD_INS_FRONT, 32'h7FFF_FFFF, 8'd0, 1, 1'b1, olpe_pkg::ST_OK, 1);
    add_row(olpe_pkg::CMD_INS_END, 32'h8000_0000, 8'd0, 1, 1'b1, olpe_pkg::ST_OK, 2);
    add_row(olpe_pkg::CMD_INS_POS, 32'h0000_0000, 8'd3, 1, 1'b0, olpe_pkg::ST_OK, 0);
    add_row(olpe_pkg::CMD_INS_POS, 32'hFFFF_FFFF, 8'd1, 1, 1'b0, olpe_pkg::ST_OK, 0);
    add_row(olpe_pkg::CMD_INS_POS, 32'd9, 8'd255, 1, 1'b1, olpe_pkg::ST_RANGE, 4);
    add_row(olpe_pkg::CMD_DEL_POS, '0, 8'd0, 1, 1'b1, olpe_pkg::ST_RANGE, 4);
    add_row(olpe_pkg::CMD_DEL_POS, '0, 8'd5, 1, 1'b1, olpe_pkg::ST_RANGE, 4);
    add_row(olpe_pkg::CMD_SHOW, '0, 8'd0, 1, 1'b0, olpe_pkg::ST_OK, 0);
    add_row(olpe_pkg::CMD_DEL_POS, '0, 8'd2, 1, 1'b0, olpe_pkg::ST_OK, 0);
    // Fill to capacity, then push against the full list
    add_row(olpe_pkg::CMD_INS_END, '0, 8'd0, 13, 1'b0, olpe_pkg::ST_OK, 0);
    add_row(olpe_pkg::CMD_INS_FRONT, 32'd1, 8'd0, 1, 1'b1, olpe_pkg::ST_FULL, olpe_pkg::DEPTH);
    add_row(olpe_pkg::CMD_INS_POS, 32'd1, 8'd0, 1, 1'b1, olpe_pkg::ST_FULL, olpe_pkg::DEPTH);
    add_row(olpe_pkg::CMD_INS_END, 32'd1, 8'd0, 1, 1'b1, olpe_pkg::ST_FULL, olpe_pkg::DEPTH);
    add_row(olpe_pkg::CMD_SHOW, '0, 8'd0, 1, 1'b0, olpe_pkg::ST_OK, 0);
    add_row(olpe_pkg::CMD_DEL_POS, '0, 8'd16, 1, 1'b0, olpe_pkg::ST_OK, 0);
    add_row(olpe_pkg::CMD_DEL_FRONT, '0, 8'd0, 1, 1'b0, olpe_pkg::ST_OK, 0);
    add_row(olpe_pkg::CMD_DEL_END, '0, 8'd0, 1, 1'b0, olpe_pkg::ST_OK, 0);
    add_row(olpe_pkg::CMD_DEL_POS, '0, 8'd7, 1, 1'b0, olpe_pkg::ST_OK, 0);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int k = 0; k < row.reps; k++)
        send_edit(row.cmd, (row.reps > 1) ? pick_value() : row.value, row.pos,
                  row.typed, row.res);
    end

    // Random part: sweep the list between empty and full, with some wild positions
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 150) begin
        hold_req    = 1'b1;
        hold_window = 1'b1;
      end
      if (n == 190) hold_window = 1'b0;
      if (shadow_len == olpe_pkg::DEPTH) filling = 1'b0;
      else if (shadow_len == 0) filling = 1'b1;
      else if ($urandom_range(0, 29) == 0) filling = !filling;
      roll = $urandom_range(0, 99);
      pos  = '0;
      if (roll < 8) cmd = olpe_pkg::CMD_SHOW;
      else if (roll < 10) begin
        cmd = CMD_UNUSED;
        pos = 8'($urandom_range(0, 255));
      end else if (roll < 16) begin
        cmd = roll[0] ? olpe_pkg::CMD_INS_POS : olpe_pkg::CMD_DEL_POS;
        pos = 8'($urandom_range(0, 255));
      end else if ($urandom_range(0, 99) < (filling ? 75 : 25)) begin
        cmd = INS_CMDS[$urandom_range(0, 2)];
        pos = 8'($urandom_range(1, shadow_len + 1));
      end else begin
        cmd = DEL_CMDS[$urandom_range(0, 2)];
        pos = 8'($urandom_range(1, (shadow_len > 0) ? shadow_len : 1));
      end
      send_edit(cmd, pick_value(), pos, 1'b0, '0);
    end

    // Drop valid and wait for the last results
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("tb: %0d commands sent (%0d displays), %0d results checked, longest list %0d",
             items_sent, shows_sent, results_checked, longest_list);
    $display("tb: full hits %0d, empty hits %0d, out of range hits %0d",
             hits_full, hits_empty, hits_range);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, bursts of steady ready, and one long hold-off
  initial begin : result_sink
    int gap;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        gap = recv_burst ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: unexpected result at %0t: st=%0d val=%0d idx=%0d cnt=%0d last=%0d",
                   $time, out_status, out_value_res, out_index, out_count, out_last);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_status !== want.status || out_value_res !== want.value ||
            out_index !== want.index || out_count !== want.count || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("tb: mismatch at %0t: exp st=%0d val=%0d idx=%0d cnt=%0d last=%0d",
                     $time, want.status, want.value, want.index, want.count, want.last);
            $display("tb:                  got st=%0d val=%0d idx=%0d cnt=%0d last=%0d",
                     out_status, out_value_res, out_index, out_count, out_last);
          end
        end
      end
    end
  end

  // Watchdog: stop if no transfer happens on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: timeout with %0d results outstanding", pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule

`default_nettype wire
